// File: hdl/ffpa_pkg.sv
// shared types and constants for the first-fit page bitmap allocator
package ffpa_pkg;

  localparam int unsigned MAX_PAGES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF = 64;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned CFG_W    = 13;
  localparam logic [CFG_W-1:0] PAGES_IN_USE_RST = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PROBE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [PAGE_W-1:0]  base_page;
    logic [COUNT_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] start_page;
    logic              is_free;
  } rsp_t;

endpackage

// File: hdl/ffpa_if.sv
// valid/ready channel carrying one payload beat
interface ffpa_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ffpa_bitmap_ram.sv
// simple dual-port used-bit word memory (one write port, one read port) with registered read
module ffpa_bitmap_ram #(
  parameter int unsigned WORDS = 64,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/first_fit_page_bitmap_allocator_core.sv
// first-fit page bitmap allocator top level
// One command in, one result beat out. The used bits live in a word memory
// (MAX_PAGES/WORD_BITS words) read one word per cycle through a registered
// read port. After reset a clearing pass writes every word to zero, one word
// a cycle (64 words by default); no command is taken meanwhile. Allocate
// scans from the hint up to the page limit, eight pages a cycle in the scan
// state: each word costs a read and a wait state, then a scan state per
// eight-page chunk. A found run is then marked with a read, a wait and a
// write-back state per word it touches; release walks the words of its range
// likewise. Probe passes the read, wait and scan states before its result. A
// finished result moves into an output register that holds it until taken;
// the core goes back to idle and takes the next command meanwhile, and that
// command's result waits until the output register frees.
module first_fit_page_bitmap_allocator_core #(
  parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned WORD_BITS = ffpa_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [ffpa_pkg::CFG_W-1:0] cfg_wdata,
  ffpa_if.sink                 in_ch,
  ffpa_if.source               out_ch
);
  import ffpa_pkg::*;

  localparam int unsigned WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int unsigned PW    = $clog2(MAX_PAGES) + 2; // page arithmetic width
  localparam int unsigned SCAN_BITS = 8;                 // pages checked per cycle in the scan state
  localparam logic [PW-1:0] MAXP = PW'(MAX_PAGES);
  localparam logic [PW-1:0] WB   = PW'(WORD_BITS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_SCAN, S_MRD, S_MWAIT, S_MWR, S_OUT
  } state_t;

  state_t           state_r;
  logic [AW-1:0]    clr_r;
  logic [CFG_W-1:0] limit_cfg_r;
  logic [PW-1:0]    hint_r;
  req_t             req_r;
  rsp_t             rsp_r;
  rsp_t             out_rsp_r;
  logic             out_valid_r;
  logic [PW-1:0]    page_r;    // current scan page
  logic [PW-1:0]    run_r;     // free run length so far
  logic [PW-1:0]    first_r;   // run start
  logic [PW-1:0]    mlo_r;     // range lo for mark/release
  logic [PW-1:0]    mhi_r;     // range hi (exclusive)
  logic             mset_r;    // marking used vs clearing

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;
  logic             load_out;

  ffpa_bitmap_ram #(.WORDS(WORDS), .WIDTH(WORD_BITS), .AW(AW)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // effective scan limit
  logic [PW-1:0] limit;
  always_comb begin
    limit = PW'(limit_cfg_r);
    if (limit > MAXP) limit = MAXP;
  end

  // word and chunk bases of the current page
  logic [PW-1:0] wbase, cbase, next_word, next_chunk;
  assign wbase      = {page_r[PW-1:BW], BW'(0)};
  assign next_word  = wbase + WB;
  assign cbase      = {page_r[PW-1:$clog2(SCAN_BITS)], ($clog2(SCAN_BITS))'(0)};
  assign next_chunk = cbase + PW'(SCAN_BITS);

  // scan of one chunk of the current word, run carried across chunks
  logic [SCAN_BITS-1:0] chunk;
  logic [PW-1:0] sc_run, sc_first;
  logic          sc_found;
  assign chunk = SCAN_BITS'(rdata >> cbase[BW-1:0]);
  always_comb begin
    logic [PW-1:0] pg;
    sc_run   = run_r;
    sc_first = first_r;
    sc_found = 1'b0;
    for (int b = 0; b < SCAN_BITS; b++) begin
      pg = cbase + PW'(b);
      if (!sc_found && pg >= page_r && pg < limit) begin
        if (chunk[b]) begin
          sc_run = '0;
        end else begin
          if (sc_run == '0) sc_first = pg;
          sc_run = sc_run + 1'b1;
          if (sc_run == PW'(req_r.page_count)) sc_found = 1'b1;
        end
      end
    end
  end

  // mask of the range inside the current word
  logic [WORD_BITS-1:0] rmask;
  always_comb begin
    logic [PW-1:0] pg;
    for (int b = 0; b < WORD_BITS; b++) begin
      pg = wbase + PW'(b);
      rmask[b] = (pg >= mlo_r) && (pg < mhi_r);
    end
  end

  // release end, clipped to store
  logic [PW:0] rel_end;
  always_comb begin
    rel_end = (PW+1)'(in_ch.payload.base_page) + (PW+1)'(in_ch.payload.page_count);
    if (rel_end > (PW+1)'(MAX_PAGES)) rel_end = (PW+1)'(MAX_PAGES);
  end

  // memory port drive
  always_comb begin
    we    = 1'b0;
    waddr = page_r[BW+AW-1:BW];
    wdata = mset_r ? (rdata | rmask) : (rdata & ~rmask);
    raddr = page_r[BW+AW-1:BW];
    if (state_r == S_CLEAR) begin
      we = 1'b1; waddr = clr_r; wdata = '0;
    end else if (state_r == S_MWR) begin
      we = 1'b1;
    end
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_rsp_r;

  // output register, loaded when empty or being taken
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
      out_rsp_r   <= rsp_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= PAGES_IN_USE_RST;
    end else if (cfg_we) begin
      limit_cfg_r <= cfg_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      hint_r      <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.payload;
            rsp_r <= '0;
            run_r <= '0;
            first_r <= '0;
            case (in_ch.payload.command)
              CMD_ALLOC: begin
                page_r <= hint_r;
                if (in_ch.payload.page_count == '0 || hint_r >= limit) begin
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_RD;
                end
              end
              CMD_RELEASE: begin
                rsp_r.ok <= 1'b1;
                if (PW'(in_ch.payload.base_page) < hint_r)
                  hint_r <= PW'(in_ch.payload.base_page);
                page_r <= PW'(in_ch.payload.base_page);
                mlo_r  <= PW'(in_ch.payload.base_page);
                mhi_r  <= rel_end[PW-1:0];
                mset_r <= 1'b0;
                if (in_ch.payload.page_count == '0 ||
                    PW'(in_ch.payload.base_page) >= MAXP) state_r <= S_OUT;
                else state_r <= S_MRD;
              end
              CMD_PROBE: begin
                page_r <= PW'(in_ch.payload.base_page);
                if (PW'(in_ch.payload.base_page) >= MAXP) state_r <= S_OUT;
                else state_r <= S_RD;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end
        S_RD:   state_r <= S_WAIT;
        S_WAIT: state_r <= S_SCAN;
        S_SCAN: begin
          if (req_r.command == CMD_PROBE) begin
            rsp_r.is_free <= ~rdata[page_r[BW-1:0]];
            rsp_r.ok      <= ~rdata[page_r[BW-1:0]];
            state_r <= S_OUT;
          end else if (sc_found) begin
            rsp_r.ok         <= 1'b1;
            rsp_r.start_page <= sc_first[PAGE_W-1:0];
            hint_r <= sc_first + PW'(req_r.page_count);
            mlo_r  <= sc_first;
            mhi_r  <= sc_first + PW'(req_r.page_count);
            mset_r <= 1'b1;
            page_r <= sc_first;
            state_r <= S_MRD;
          end else begin
            // next chunk, in the same word or after a fresh read, or finish at the limit
            run_r   <= sc_run;
            first_r <= sc_first;
            page_r  <= next_chunk;
            if (next_chunk >= limit) state_r <= S_OUT;
            else if (next_chunk[BW-1:0] == '0) state_r <= S_RD;
          end
        end
        S_MRD:   state_r <= S_MWAIT;
        S_MWAIT: state_r <= S_MWR;
        S_MWR: begin
          page_r <= next_word;
          if (next_word >= mhi_r) state_r <= S_OUT;
          else state_r <= S_MRD;
        end
        S_OUT: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a waiting result beat stays put until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.payload)))
    else $error("result beat changed while waiting");
  // memory written only in clear or write-back
  assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLEAR || state_r == S_MWR)) else $error("stray write");
  // the hint never points past the store
  assert property (@(posedge clk) disable iff (!rst_n)
    hint_r <= MAXP) else $error("hint past store");
endmodule
